FILE: sv/gnd_pkg.sv
// ----------------------------------------------------------------------------
// gnd_pkg
// shared types, codes and offset tables of the neighbourhood difference block
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned NbCells = 9;
  localparam int unsigned MaskW   = 2 * NbCells;
  localparam int unsigned IdxW    = $clog2(MaskW);

  localparam logic [CfgIdxW-1:0] RegGridWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegGridHeight = CfgIdxW'(1);

  localparam logic KindAdded   = 1'b0;
  localparam logic KindRemoved = 1'b1;

  // one queued transaction: both centres and the set of cells to report
  // mask bits 0..8 added cells, 9..17 removed cells, dy outer and dx inner
  typedef struct packed {
    logic [MaskW-1:0]  mask;
    logic [CoordW-1:0] new_row;
    logic [CoordW-1:0] new_col;
    logic [CoordW-1:0] old_row;
    logic [CoordW-1:0] old_col;
  } entry_t;

  // column offset of a mask bit, as an 8-bit two's complement value
  function automatic logic [CoordW-1:0] dx_off(logic [IdxW-1:0] idx);
    logic [CoordW-1:0] off;
    case (idx) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:  off = '1;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: off = '0;
      default:                               off = CoordW'(1);
    endcase
    return off;
  endfunction

  // row offset of a mask bit, as an 8-bit two's complement value
  function automatic logic [CoordW-1:0] dy_off(logic [IdxW-1:0] idx);
    logic [CoordW-1:0] off;
    case (idx) inside
      5'd0, 5'd1, 5'd2, 5'd9, 5'd10, 5'd11:   off = '1;
      5'd3, 5'd4, 5'd5, 5'd12, 5'd13, 5'd14:  off = '0;
      default:                                off = CoordW'(1);
    endcase
    return off;
  endfunction

endpackage

FILE: sv/grid_neighbourhood_diff_top.sv
// ----------------------------------------------------------------------------
// grid_neighbourhood_diff_top
// 3x3 neighbourhood difference of an old and a new sector on a sized grid
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata old_col, old_row, new_col, new_row
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata cell_col, cell_row; tuser kind,
//                                                    empty_res; tlast last
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// one result per cycle while m_axis_tready is high: a transaction with n reported cells
// gives n results (1 for an empty difference), from 1 up to 18, set by the emitter; an
// accepted input passes the queue, the emitter's working register and the output register;
// input is taken while the queue has room, so the front keeps accepting while results
// wait on m_axis; reset clears the queue and the emitter; grid size resets to 16 by 16
// ----------------------------------------------------------------------------
module grid_neighbourhood_diff_top #(
  parameter int unsigned MAX_GRID   = 256,
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // old_col, old_row, new_col, new_row
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // cell_col, cell_row
  output logic [1:0]                   m_axis_tuser,   // kind, empty_res
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gnd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gnd_pkg::CfgW-1:0]     cfg_data_i
);

  gnd_pkg::entry_t front_entry, q_entry;
  logic            q_full, q_valid, q_pop, push;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  gnd_front #(
    .MAX_GRID (MAX_GRID)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .old_col_i   (s_axis_tdata[7:0]),
    .old_row_i   (s_axis_tdata[15:8]),
    .new_col_i   (s_axis_tdata[23:16]),
    .new_row_i   (s_axis_tdata[31:24]),
    .entry_o     (front_entry)
  );

  gnd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  gnd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser[0]),
    .cell_col_o  (m_axis_tdata[7:0]),
    .cell_row_o  (m_axis_tdata[15:8]),
    .empty_res_o (m_axis_tuser[1]),
    .last_o      (m_axis_tlast)
  );

endmodule

FILE: sv/gnd_front.sv
// ----------------------------------------------------------------------------
// gnd_front
// grid size registers and classification of the 18 candidate cells
// ----------------------------------------------------------------------------
module gnd_front #(
  parameter int unsigned MAX_GRID = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [gnd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gnd_pkg::CfgW-1:0]       cfg_data_i,
  input  logic [gnd_pkg::CoordW-1:0]     old_col_i,
  input  logic [gnd_pkg::CoordW-1:0]     old_row_i,
  input  logic [gnd_pkg::CoordW-1:0]     new_col_i,
  input  logic [gnd_pkg::CoordW-1:0]     new_row_i,
  output gnd_pkg::entry_t                entry_o
);

  logic [gnd_pkg::CfgW-1:0] width_q, width_d;
  logic [gnd_pkg::CfgW-1:0] height_q, height_d;
  logic [9:0]               eff_w, eff_h;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == gnd_pkg::RegGridWidth) begin
        width_d = cfg_data_i;
      end else if (cfg_index_i == gnd_pkg::RegGridHeight) begin
        height_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gnd_pkg::CfgW'(16);
      height_q <= gnd_pkg::CfgW'(16);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // saturate to the largest supported grid
  assign eff_w = (32'(width_q) > MAX_GRID) ? 10'(MAX_GRID) : {1'b0, width_q};
  assign eff_h = (32'(height_q) > MAX_GRID) ? 10'(MAX_GRID) : {1'b0, height_q};

  // cell of centre (cx,cy) at offset (dx,dy) is in the grid and not near (ox,oy)
  function automatic logic keep_cell(logic [7:0] cx, logic [7:0] cy, int dx, int dy,
                                     logic [7:0] ox, logic [7:0] oy,
                                     logic [9:0] w, logic [9:0] h);
    logic signed [10:0] x, y, ddx, ddy;
    logic               ok, nx, ny;
    x   = $signed({3'b000, cx}) + 11'(dx);
    y   = $signed({3'b000, cy}) + 11'(dy);
    ok  = (x >= 0) && (x < $signed({1'b0, w})) && (y >= 0) && (y < $signed({1'b0, h}));
    ddx = x - $signed({3'b000, ox});
    ddy = y - $signed({3'b000, oy});
    nx  = (ddx >= -1) && (ddx <= 1);
    ny  = (ddy >= -1) && (ddy <= 1);
    return ok && !(nx && ny);
  endfunction

  always_comb begin
    entry_o.old_col = old_col_i;
    entry_o.old_row = old_row_i;
    entry_o.new_col = new_col_i;
    entry_o.new_row = new_row_i;
    entry_o.mask    = '0;
    for (int dyi = 0; dyi < 3; dyi++) begin
      for (int dxi = 0; dxi < 3; dxi++) begin
        entry_o.mask[dyi*3 + dxi] =
          keep_cell(new_col_i, new_row_i, dxi - 1, dyi - 1, old_col_i, old_row_i, eff_w, eff_h);
        entry_o.mask[gnd_pkg::NbCells + dyi*3 + dxi] =
          keep_cell(old_col_i, old_row_i, dxi - 1, dyi - 1, new_col_i, new_row_i, eff_w, eff_h);
      end
    end
  end

endmodule

FILE: sv/gnd_fifo.sv
// ----------------------------------------------------------------------------
// gnd_fifo
// short register queue between classification and emission
// ----------------------------------------------------------------------------
module gnd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gnd_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gnd_pkg::entry_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  gnd_pkg::entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/gnd_back.sv
// ----------------------------------------------------------------------------
// gnd_back
// walks the cell mask of one transaction and emits one result per cycle while out_ready_i allows
// ----------------------------------------------------------------------------
module gnd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  gnd_pkg::entry_t             q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [gnd_pkg::CoordW-1:0]  cell_col_o,
  output logic [gnd_pkg::CoordW-1:0]  cell_row_o,
  output logic                        empty_res_o,
  output logic                        last_o
);

  localparam int unsigned MaskW = gnd_pkg::MaskW;
  localparam int unsigned IdxW  = gnd_pkg::IdxW;

  logic                        w_valid_q, w_valid_d;
  gnd_pkg::entry_t             w_q, w_d;
  logic                        o_valid_q, o_valid_d;
  logic                        o_kind_q, o_kind_d, o_empty_q, o_empty_d, o_last_q, o_last_d;
  logic [gnd_pkg::CoordW-1:0]  o_col_q, o_col_d, o_row_q, o_row_d;

  logic                        out_free, emit, w_done, pop, is_empty, sel_kind;
  logic [MaskW-1:0]            low, rem;
  logic [IdxW-1:0]             idx;
  logic [gnd_pkg::CoordW-1:0]  base_col, base_row;

  assign out_free = !o_valid_q || out_ready_i;
  assign emit     = w_valid_q && out_free;
  assign is_empty = (w_q.mask == '0);
  assign low      = w_q.mask & (~w_q.mask + MaskW'(1));
  assign rem      = w_q.mask & (w_q.mask - MaskW'(1));
  assign w_done   = emit && (is_empty || (rem == '0));
  assign pop      = q_valid_i && (!w_valid_q || w_done);
  assign q_pop_o  = pop;

  always_comb begin
    idx = '0;
    for (int i = 0; i < MaskW; i++) begin
      if (low[i]) begin
        idx = idx | IdxW'(i);
      end
    end
  end

  assign sel_kind = (idx >= IdxW'(gnd_pkg::NbCells)) ? gnd_pkg::KindRemoved
                                                     : gnd_pkg::KindAdded;
  assign base_col = (sel_kind == gnd_pkg::KindRemoved) ? w_q.old_col : w_q.new_col;
  assign base_row = (sel_kind == gnd_pkg::KindRemoved) ? w_q.old_row : w_q.new_row;

  always_comb begin
    w_valid_d = w_valid_q;
    w_d       = w_q;
    if (pop) begin
      w_valid_d = 1'b1;
      w_d       = q_data_i;
    end else begin
      if (w_done) begin
        w_valid_d = 1'b0;
      end
      if (emit) begin
        w_d.mask = rem;
      end
    end
  end

  always_comb begin
    o_valid_d = o_valid_q;
    o_kind_d  = o_kind_q;
    o_col_d   = o_col_q;
    o_row_d   = o_row_q;
    o_empty_d = o_empty_q;
    o_last_d  = o_last_q;
    if (out_free) begin
      o_valid_d = emit;
    end
    if (emit) begin
      if (is_empty) begin
        o_kind_d  = gnd_pkg::KindAdded;
        o_col_d   = '0;
        o_row_d   = '0;
        o_empty_d = 1'b1;
        o_last_d  = 1'b1;
      end else begin
        o_kind_d  = sel_kind;
        o_col_d   = base_col + gnd_pkg::dx_off(idx);
        o_row_d   = base_row + gnd_pkg::dy_off(idx);
        o_empty_d = 1'b0;
        o_last_d  = (rem == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      w_valid_q <= w_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    o_kind_q  <= o_kind_d;
    o_col_q   <= o_col_d;
    o_row_q   <= o_row_d;
    o_empty_q <= o_empty_d;
    o_last_q  <= o_last_d;
  end

  assign out_valid_o = o_valid_q;
  assign kind_o      = o_kind_q;
  assign cell_col_o  = o_col_q;
  assign cell_row_o  = o_row_q;
  assign empty_res_o = o_empty_q;
  assign last_o      = o_last_q;

endmodule
